[src/pba_pkg.sv]
// shared types, constants and helpers of the page bitmap allocator
`timescale 1ns / 1ps

package pba_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int NUM_WORDS  = NUM_PAGES / WORD_W;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int PAGE_W     = 12;
	localparam int OP_W       = 3;
	localparam int REG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int BOUND_W    = ($clog2(NUM_PAGES + 1) > REG_W) ? $clog2(NUM_PAGES + 1) : REG_W;

	localparam int HOLE_FIRST_PAGE = 32'h000A0000 >> 12;
	localparam int HOLE_END_PAGE   = 32'h000D8000 >> 12;

	localparam logic [OP_W-1:0] OP_ALLOC_ANY  = 3'd0;
	localparam logic [OP_W-1:0] OP_ALLOC_HIGH = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC_LOW  = 3'd2;
	localparam logic [OP_W-1:0] OP_FREE       = 3'd3;
	localparam logic [OP_W-1:0] OP_RESERVE    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAGE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_START  = 2'd2;

	localparam logic [REG_W-1:0] MAX_PAGE_RST   = 13'd4096;
	localparam logic [REG_W-1:0] HIGH_START_RST = 13'd4096;
	localparam logic [REG_W-1:0] LOW_START_RST  = 13'd0;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PAGE_W-1:0] page;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] result_page;
		logic              ok;
	} rsp_t;

	typedef struct packed {
		logic [REG_W-1:0] max_page;
		logic [REG_W-1:0] high_start_page;
		logic [REG_W-1:0] low_start_page;
	} cfg_t;

	typedef struct packed {
		logic               re;
		logic [WADDR_W-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic               we;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
	} ram_wr_t;

	// bitmap word after reset: the bios and video hole is marked used
	function automatic logic [WORD_W-1:0] reset_word(input logic [WADDR_W-1:0] addr);
		logic [WORD_W-1:0]          w;
		logic [WADDR_W+BIT_W-1:0]   p;
		w = '0;
		for (int b = 0; b < WORD_W; b++) begin
			p = {addr, BIT_W'(b)};
			w[b] = (32'(p) >= 32'(HOLE_FIRST_PAGE)) && (32'(p) < 32'(HOLE_END_PAGE));
		end
		return w;
	endfunction

endpackage

[src/pba_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module pba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/pba_cfg.sv]
// configuration registers of the page bitmap allocator
`timescale 1ns / 1ps

module pba_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pba_pkg::REG_W-1:0]      cfg_data,
	output pba_pkg::cfg_t                  cfg
);

	pba_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_page        <= pba_pkg::MAX_PAGE_RST;
			cfg_q.high_start_page <= pba_pkg::HIGH_START_RST;
			cfg_q.low_start_page  <= pba_pkg::LOW_START_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pba_pkg::REG_MAX_PAGE:   cfg_q.max_page        <= cfg_data;
				pba_pkg::REG_HIGH_START: cfg_q.high_start_page <= cfg_data;
				pba_pkg::REG_LOW_START:  cfg_q.low_start_page  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/pba_engine.sv]
// sequencer: first-fit word scan, free and reserve read-modify-write of the bitmap
`timescale 1ns / 1ps

module pba_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pba_pkg::req_t              req,
	input  pba_pkg::cfg_t              cfg,
	output logic                       done,
	output pba_pkg::rsp_t              rsp,
	output pba_pkg::ram_rd_t           rd,
	output pba_pkg::ram_wr_t           wr,
	input  logic [pba_pkg::WORD_W-1:0] rdata
);

	localparam int WORD_W  = pba_pkg::WORD_W;
	localparam int BIT_W   = pba_pkg::BIT_W;
	localparam int WADDR_W = pba_pkg::WADDR_W;
	localparam int BOUND_W = pba_pkg::BOUND_W;
	localparam int PAGE_W  = pba_pkg::PAGE_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_RD    = 5'b01000,
		ST_WB    = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [pba_pkg::OP_W-1:0] op_q;
	logic [PAGE_W-1:0]        page_q;
	logic                     region_high_q;
	logic [WADDR_W-1:0]       first_word_q;
	logic [BIT_W-1:0]         first_bit_q;
	logic [WADDR_W-1:0]       last_q;
	logic [BIT_W-1:0]         last_bit_q;
	logic [WADDR_W-1:0]       rd_ptr_q;
	logic                     issue_q;
	logic                     wvalid_q [pba_pkg::NUM_WORDS];
	logic                     vld_s1;
	logic                     wvalid_s1;
	logic [WADDR_W-1:0]       addr_s1;
	logic                     done_q;
	pba_pkg::rsp_t            rsp_q;

	logic [BOUND_W-1:0] page_ext;
	logic               page_in_range;
	logic [BOUND_W-1:0] max_ext, high_ext, low_ext, npages;
	logic [BOUND_W-1:0] set_first, set_end, set_last;
	logic               set_empty;
	logic               try_low;
	logic [WORD_W-1:0]  eff_word, lo_mask, hi_mask, free_bits, flip;
	logic               hit;
	logic [BIT_W-1:0]   hit_idx;
	logic               wb_bit, wb_change;

	assign page_ext      = BOUND_W'(page_q);
	assign page_in_range = BOUND_W'(req.page) < BOUND_W'(pba_pkg::NUM_PAGES);
	assign max_ext       = BOUND_W'(cfg.max_page);
	assign high_ext      = BOUND_W'(cfg.high_start_page);
	assign low_ext       = BOUND_W'(cfg.low_start_page);
	assign npages        = BOUND_W'(pba_pkg::NUM_PAGES);
	assign try_low       = region_high_q && (op_q == pba_pkg::OP_ALLOC_ANY);

	// search range of the current region
	always_comb begin
		if (region_high_q) begin
			set_first = high_ext;
			set_end   = (max_ext < npages) ? max_ext : npages;
			set_empty = !(max_ext > high_ext) || (set_first >= set_end);
		end else begin
			set_first = low_ext;
			set_end   = (high_ext < max_ext) ? high_ext : max_ext;
			if (npages < set_end) begin
				set_end = npages;
			end
			set_empty = set_first >= set_end;
		end
		set_last = set_end - BOUND_W'(1);
	end

	assign eff_word = wvalid_s1 ? rdata : pba_pkg::reset_word(addr_s1);

	always_comb begin
		lo_mask   = (addr_s1 == first_word_q) ? ({WORD_W{1'b1}} << first_bit_q) : '1;
		hi_mask   = (addr_s1 == last_q) ?
			({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit_q)) : '1;
		free_bits = ~eff_word & lo_mask & hi_mask;
		hit       = |free_bits;
		hit_idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				hit_idx = BIT_W'(i);
			end
		end
	end

	assign wb_bit    = eff_word[page_q[BIT_W-1:0]];
	assign wb_change = (op_q == pba_pkg::OP_FREE) ? wb_bit : !wb_bit;

	always_comb begin
		flip = '0;
		if (state_q == ST_SCAN) begin
			flip[hit_idx] = 1'b1;
		end else begin
			flip[page_q[BIT_W-1:0]] = 1'b1;
		end
	end

	assign rd.re   = ((state_q == ST_SCAN) && issue_q) || (state_q == ST_RD);
	assign rd.addr = (state_q == ST_RD) ? page_ext[BIT_W +: WADDR_W] : rd_ptr_q;

	assign wr.we   = ((state_q == ST_SCAN) && vld_s1 && hit) || ((state_q == ST_WB) && wb_change);
	assign wr.addr = addr_s1;
	assign wr.data = eff_word ^ flip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= '0;
			page_q        <= '0;
			region_high_q <= 1'b0;
			first_word_q  <= '0;
			first_bit_q   <= '0;
			last_q        <= '0;
			last_bit_q    <= '0;
			rd_ptr_q      <= '0;
			issue_q       <= 1'b0;
			vld_s1        <= 1'b0;
			wvalid_s1     <= 1'b0;
			addr_s1       <= '0;
			done_q        <= 1'b0;
			rsp_q         <= '0;
			for (int i = 0; i < pba_pkg::NUM_WORDS; i++) begin
				wvalid_q[i] <= 1'b0;
			end
		end else begin
			done_q    <= 1'b0;
			vld_s1    <= rd.re;
			addr_s1   <= rd.addr;
			wvalid_s1 <= wvalid_q[rd.addr];
			if (wr.we) begin
				wvalid_q[wr.addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= req.op;
						page_q <= req.page;
						unique case (req.op)
							pba_pkg::OP_ALLOC_ANY, pba_pkg::OP_ALLOC_HIGH: begin
								region_high_q <= 1'b1;
								state_q       <= ST_SETUP;
							end
							pba_pkg::OP_ALLOC_LOW: begin
								region_high_q <= 1'b0;
								state_q       <= ST_SETUP;
							end
							pba_pkg::OP_FREE, pba_pkg::OP_RESERVE: begin
								if (page_in_range) begin
									state_q <= ST_RD;
								end else begin
									done_q            <= 1'b1;
									rsp_q.result_page <= req.page;
									rsp_q.ok          <= 1'b0;
								end
							end
							default: begin
								done_q            <= 1'b1;
								rsp_q.result_page <= req.page;
								rsp_q.ok          <= 1'b0;
							end
						endcase
					end
				end
				ST_SETUP: begin
					if (set_empty) begin
						if (try_low) begin
							region_high_q <= 1'b0;
						end else begin
							done_q  <= 1'b1;
							rsp_q   <= '0;
							state_q <= ST_IDLE;
						end
					end else begin
						first_word_q <= set_first[BIT_W +: WADDR_W];
						first_bit_q  <= set_first[BIT_W-1:0];
						rd_ptr_q     <= set_first[BIT_W +: WADDR_W];
						last_q       <= set_last[BIT_W +: WADDR_W];
						last_bit_q   <= set_last[BIT_W-1:0];
						issue_q      <= 1'b1;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (rd_ptr_q == last_q) begin
							issue_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + WADDR_W'(1);
						end
					end
					if (vld_s1) begin
						if (hit) begin
							issue_q           <= 1'b0;
							done_q            <= 1'b1;
							rsp_q.result_page <= PAGE_W'({addr_s1, hit_idx});
							rsp_q.ok          <= 1'b1;
							state_q           <= ST_IDLE;
						end else if (addr_s1 == last_q) begin
							if (try_low) begin
								region_high_q <= 1'b0;
								state_q       <= ST_SETUP;
							end else begin
								done_q  <= 1'b1;
								rsp_q   <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					done_q            <= 1'b1;
					rsp_q.result_page <= page_q;
					rsp_q.ok          <= wb_change;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_write_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == ST_SCAN || state_q == ST_WB))
		else $error("bitmap write outside scan or write-back");

	a_write_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |=> done_q)
		else $error("bitmap write without a result word");

	a_wb_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |=> (done_q && state_q == ST_IDLE))
		else $error("write-back did not complete");

	a_issue_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> (state_q == ST_SCAN))
		else $error("word read issued outside scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && vld_s1) |-> (addr_s1 <= last_q && addr_s1 >= first_word_q))
		else $error("scan word outside search range");

endmodule

[src/page_bitmap_allocator.sv]
// top level of the page bitmap allocator: config registers, sequencer and bitmap ram
// flow: free and reserve read the bitmap word and then write it back; unused op codes are refused
//   with no bitmap access; an allocation scans words in order, and an alloc-any scan falls back from high to low
// requests: one at a time
// reset: word valid flops clear at once, so the bitmap reads free but for the bios and video
//   hole with no clearing pass; the receiver cannot stall the result
`timescale 1ns / 1ps

module page_bitmap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pba_pkg::req_t                 req,
	output logic                          done,
	output pba_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pba_pkg::REG_W-1:0]     cfg_data
);

	pba_pkg::cfg_t                cfg;
	pba_pkg::ram_rd_t             rd;
	pba_pkg::ram_wr_t             wr;
	logic [pba_pkg::WORD_W-1:0]   rdata;

	pba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pba_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.cfg    (cfg),
		.done   (done),
		.rsp    (rsp),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	pba_ram #(
		.WIDTH (pba_pkg::WORD_W),
		.DEPTH (pba_pkg::NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (rdata)
	);

endmodule

[tb/testbench.sv]
// testbench of the page bitmap allocator: directed table, then random words checked against a bitmap predictor
`timescale 1ns / 1ps

module testbench;
	import pba_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
	localparam bit TYPED     = 1'b1;
	localparam bit PREDICTED = 1'b0;
	localparam int DIR_N     = 24;
	localparam int PLAN_N    = 7;
	localparam int DRAIN_CYCLES = 2 * NUM_WORDS + 40;

	typedef struct packed {
		req_t cmd;
		bit   typed;
		rsp_t want;
	} row_t;

	typedef struct packed {
		logic [REG_W-1:0]  max_pg;
		logic [REG_W-1:0]  high_pg;
		logic [REG_W-1:0]  low_pg;
		logic [PAGE_W-1:0] win_lo;
		logic [PAGE_W-1:0] win_hi;
		logic [15:0]       words;
	} bounds_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req = '0;
	logic              done;
	rsp_t              rsp;
	logic              cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]  cfg_data = '0;

	bit                page_taken [NUM_PAGES];
	logic [REG_W-1:0]  cur_max;
	logic [REG_W-1:0]  cur_high;
	logic [REG_W-1:0]  cur_low;
	rsp_t              pending_rsp [$];
	row_t              word_q [$];
	rsp_t              oldest;
	int                err_count = 0;

	row_t directed_rows [DIR_N] = '{
		{OP_ALLOC_ANY,  12'hFFF, TYPED, 12'd0,    1'b1},
		{OP_ALLOC_HIGH, 12'h000, TYPED, 12'd0,    1'b0},
		{OP_ALLOC_LOW,  12'hFFF, TYPED, 12'd1,    1'b1},
		{OP_FREE,       12'd0,   TYPED, 12'd0,    1'b1},
		{OP_FREE,       12'd0,   TYPED, 12'd0,    1'b0},
		{OP_RESERVE,    12'd160, TYPED, 12'd160,  1'b0},
		{OP_FREE,       12'd160, TYPED, 12'd160,  1'b1},
		{OP_RESERVE,    12'd160, TYPED, 12'd160,  1'b1},
		{OP_RESERVE,    12'hFFF, TYPED, 12'hFFF,  1'b1},
		{OP_RESERVE,    12'hFFF, TYPED, 12'hFFF,  1'b0},
		{OP_FREE,       12'hFFF, TYPED, 12'hFFF,  1'b1},
		{OP_SPARE_A,    12'hFFF, TYPED, 12'hFFF,  1'b0},
		{OP_SPARE_B,    12'hAAA, TYPED, 12'hAAA,  1'b0},
		{OP_SPARE_C,    12'h555, TYPED, 12'h555,  1'b0},
		{OP_ALLOC_LOW,  12'hFFF, TYPED, 12'd0,    1'b1},
		{OP_ALLOC_ANY,  12'h555, TYPED, 12'd2,    1'b1},
		{OP_RESERVE,    12'd3,   TYPED, 12'd3,    1'b1},
		{OP_ALLOC_ANY,  12'hAAA, TYPED, 12'd4,    1'b1},
		{OP_FREE,       12'd215, TYPED, 12'd215,  1'b1},
		{OP_FREE,       12'd216, TYPED, 12'd216,  1'b0},
		{OP_RESERVE,    12'd159, TYPED, 12'd159,  1'b1},
		{OP_FREE,       12'd159, TYPED, 12'd159,  1'b1},
		{OP_ALLOC_ANY,  12'h000, PREDICTED, 12'd0, 1'b0},
		{OP_RESERVE,    12'd215, PREDICTED, 12'd0, 1'b0}
	};

	bounds_t bounds_plan [PLAN_N] = '{
		{13'd4096, 13'd4096, 13'd0,    12'd0,    12'd300,  16'd220},
		{13'd300,  13'd280,  13'd250,  12'd240,  12'd310,  16'd260},
		{13'd8191, 13'd4064, 13'd4000, 12'd3990, 12'd4095, 16'd260},
		{13'd0,    13'd0,    13'd0,    12'd0,    12'd4095, 16'd60},
		{13'd240,  13'd200,  13'd150,  12'd140,  12'd250,  16'd260},
		{13'd8191, 13'd8191, 13'd8191, 12'd4000, 12'd4095, 16'd60},
		{13'd100,  13'd3000, 13'd90,   12'd80,   12'd110,  16'd200}
	};

	int idle_plan [3] = '{0, 48, 23};

	page_bitmap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// first free page in [first, stop), stop clamped to the bitmap size
	function automatic bit claim_first(input int first, input int stop,
			output logic [PAGE_W-1:0] pg);
		int lim;
		lim = (stop < NUM_PAGES) ? stop : NUM_PAGES;
		pg = '0;
		for (int p = first; p < lim; p++) begin
			if (!page_taken[p]) begin
				page_taken[p] = 1'b1;
				pg = PAGE_W'(p);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic rsp_t bitmap_apply(input req_t r);
		rsp_t              o;
		logic [PAGE_W-1:0] pg;
		bit                hit;
		int                mx;
		int                hi;
		int                lo;
		mx = int'(cur_max);
		hi = int'(cur_high);
		lo = int'(cur_low);
		o.result_page = r.page;
		o.ok = 1'b0;
		hit = 1'b0;
		pg = '0;
		case (r.op)
			OP_ALLOC_ANY, OP_ALLOC_HIGH, OP_ALLOC_LOW: begin
				if (r.op != OP_ALLOC_LOW && mx > hi)
					hit = claim_first(hi, mx, pg);
				if (!hit && r.op != OP_ALLOC_HIGH)
					hit = claim_first(lo, (hi < mx) ? hi : mx, pg);
				o.result_page = hit ? pg : '0;
				o.ok = hit;
			end
			OP_FREE: begin
				if (page_taken[r.page]) begin
					page_taken[r.page] = 1'b0;
					o.ok = 1'b1;
				end
			end
			OP_RESERVE: begin
				if (!page_taken[r.page]) begin
					page_taken[r.page] = 1'b1;
					o.ok = 1'b1;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic row_t random_word(input logic [PAGE_W-1:0] win_lo,
			input logic [PAGE_W-1:0] win_hi);
		row_t w;
		int   pick;
		w = '0;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 85)
			w.cmd.page = PAGE_W'($urandom_range(win_lo, win_hi));
		else
			w.cmd.page = PAGE_W'($urandom);
		if (pick < 45)
			w.cmd.op = OP_W'($urandom_range(OP_ALLOC_ANY, OP_ALLOC_LOW));
		else if (pick < 75)
			w.cmd.op = OP_FREE;
		else if (pick < 93)
			w.cmd.op = OP_RESERVE;
		else
			w.cmd.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
		return w;
	endfunction

	// one word per start/busy handshake
	task automatic drive_words(input int idle_pct);
		row_t w;
		int   gap;
		int   k;
		k = 0;
		while (word_q.size() != 0) begin
			w = word_q.pop_front();
			gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
			if (k % 97 == 50) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
			end else if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			start <= 1'b1;
			req <= w.cmd;
			do @(posedge clk); while (busy !== 1'b0);
			oldest = bitmap_apply(w.cmd);
			pending_rsp.push_back(w.typed ? w.want : oldest);
			k++;
		end
		start <= 1'b0;
	endtask

	task automatic program_bounds(input bounds_t b);
		while (pending_rsp.size() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_PAGE;
		cfg_data <= b.max_pg;
		@(posedge clk);
		cfg_index <= REG_HIGH_START;
		cfg_data <= b.high_pg;
		@(posedge clk);
		cfg_index <= REG_LOW_START;
		cfg_data <= b.low_pg;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max = b.max_pg;
		cur_high = b.high_pg;
		cur_low = b.low_pg;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result page %0d ok %0d", $time,
					rsp.result_page, rsp.ok);
				err_count++;
			end else begin
				oldest = pending_rsp.pop_front();
				if (rsp.result_page !== oldest.result_page || rsp.ok !== oldest.ok) begin
					$display("%0t: expected page %0d ok %0d, got page %0d ok %0d", $time,
						oldest.result_page, oldest.ok, rsp.result_page, rsp.ok);
					err_count++;
				end
			end
		end
	end

	initial begin
		for (int p = 0; p < NUM_PAGES; p++)
			page_taken[p] = (p >= HOLE_FIRST_PAGE) && (p < HOLE_END_PAGE);
		cur_max = MAX_PAGE_RST;
		cur_high = HIGH_START_RST;
		cur_low = LOW_START_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			word_q.push_back(directed_rows[i]);
		drive_words(0);

		for (int s = 0; s < PLAN_N; s++) begin
			program_bounds(bounds_plan[s]);
			for (int i = 0; i < int'(bounds_plan[s].words); i++)
				word_q.push_back(random_word(bounds_plan[s].win_lo, bounds_plan[s].win_hi));
			drive_words(idle_plan[s % 3]);
		end

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("page_bitmap_allocator regression: pass");
		else
			$display("page_bitmap_allocator regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("page_bitmap_allocator regression: fail");
		$finish;
	end

endmodule
